// File: hw/rtl/sha256_byte_stream_hasher_assert.svh
// Assertion macros shared by the hasher RTL files.
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`ifndef SYNTHESIS
`define SHA_ASSERT_IMPL(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define SHA_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define SHA_ASSERT_IMPL(label, clk, rst, prop, msg)
`define SHA_ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// File: hw/rtl/sha_pkg.sv
// Types, constants and round functions for the SHA-256 hasher.
package sha_pkg;

  typedef logic [31:0] word_t;

  // Request passed from the front to the back through the queue.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } back_state_t;

  localparam word_t INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;

  function automatic word_t round_const(input logic [5:0] t);
    word_t k [64];
    k = '{
      32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
      32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
      32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
      32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
      32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
      32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
      32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
      32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
      32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
      32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
      32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
    return k[t];
  endfunction

  function automatic word_t ror(input word_t v, input int s);
    return (v >> s) | (v << (32 - s));
  endfunction

endpackage

// File: hw/rtl/sha_front.sv
// Input front: accepts requests, drops empty non-last ones, feeds a small queue.
`include "sha256_byte_stream_hasher_assert.svh"
module sha_front
  import sha_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  req_t       in_req,
  output logic       q_valid,
  input  logic       q_pop,
  output req_t       q_req
);
  localparam int DEPTH = 4;
  req_t       mem [DEPTH];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;
  logic       push, pop;

  assign in_ready = (count != 3'(DEPTH));
  // Items that carry no byte and no end mark have no effect and are dropped.
  assign push = in_valid && in_ready && (in_req.has_byte || in_req.last_byte);
  assign q_valid = (count != 3'd0);
  assign pop = q_pop && q_valid;
  assign q_req = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

  `SHA_ASSERT_NEVER(a_no_overflow, clk, rst, count > 3'(DEPTH), "queue count overflow")
  `SHA_ASSERT_IMPL(a_pop_nonempty, clk, rst, q_pop |-> q_valid, "pop from empty queue")
  `SHA_ASSERT_IMPL(a_full_stall, clk, rst, (count == 3'(DEPTH)) |-> !in_ready, "full not stalled")
endmodule

// File: hw/rtl/sha_back.sv
// Back end: block buffer, padding, 64-round compression and digest output.
`include "sha256_byte_stream_hasher_assert.svh"
module sha_back
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_pop,
  input  req_t        q_req,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_word,
  output logic [2:0]  out_index,
  output logic        out_last
);
  back_state_t state, state_next;

  word_t       buf_mem [16];
  logic [5:0]  byte_position;
  logic [63:0] message_bit_count;
  word_t       hash_words [8];
  word_t       wv [8];
  word_t       sched [16];
  logic [6:0]  round_counter;
  logic        final_blk;   // block being compressed holds the length and ends the message
  logic        need_pad;    // the message has ended and its padding is not finished
  logic [5:0]  pad_pos;
  logic        pad_mark_done;
  logic [2:0]  emit_idx;
  logic [4:0]  load_idx;    // sixteen word reads, then a final step to take the last word

  // Buffer write port, one byte a cycle while taking input or padding.
  logic       bw_en;
  logic [5:0] bw_addr;
  logic [7:0] bw_data;
  // Buffer read: one schedule word a cycle during load.
  word_t      load_word;

  // Bytes are kept big-endian inside each schedule word.
  always_ff @(posedge clk) begin
    if (bw_en) buf_mem[bw_addr[5:2]][{~bw_addr[1:0], 3'b000} +: 8] <= bw_data;
  end
  always_ff @(posedge clk) begin
    load_word <= buf_mem[load_idx[3:0]];
  end

  // Round datapath.
  word_t w15, w2, sg0, sg1, wnew, wt, big1, chs, big0, mj, t1, t2;
  logic  in_sched;
  assign in_sched = round_counter[6:4] != 3'd0;
  assign w15  = sched[1];
  assign w2   = sched[14];
  assign sg0  = ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3);
  assign sg1  = ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10);
  assign wnew = sched[0] + sg0 + sched[9] + sg1;
  assign wt   = in_sched ? wnew : sched[0];
  assign big1 = ror(wv[4], 6) ^ ror(wv[4], 11) ^ ror(wv[4], 25);
  assign chs  = (wv[4] & wv[5]) ^ (~wv[4] & wv[6]);
  assign t1   = wv[7] + big1 + chs + round_const(round_counter[5:0]) + wt;
  assign big0 = ror(wv[0], 2) ^ ror(wv[0], 13) ^ ror(wv[0], 22);
  assign mj   = (wv[0] & wv[1]) ^ (wv[0] & wv[2]) ^ (wv[1] & wv[2]);
  assign t2   = big0 + mj;

  // Byte written during padding; the length goes out most significant byte first.
  logic [63:0] len_shift;
  logic [7:0]  pad_byte;
  assign len_shift = message_bit_count >> {~pad_pos[2:0], 3'b000};
  always_comb begin
    if (!pad_mark_done) pad_byte = PAD_MARK;
    else if (final_blk && pad_pos >= LEN_POS) pad_byte = len_shift[7:0];
    else pad_byte = 8'h00;
  end

  always_comb begin
    state_next = state;
    q_pop = 1'b0;
    bw_en = 1'b0;
    bw_addr = byte_position;
    bw_data = q_req.data_byte;
    unique case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          bw_en = q_req.has_byte;
          if (q_req.has_byte && byte_position == 6'd63) state_next = ST_LOAD;
          else if (q_req.last_byte) state_next = ST_PAD;
        end
      end
      ST_PAD: begin
        bw_en = 1'b1;
        bw_addr = pad_pos;
        bw_data = pad_byte;
        if (pad_pos == 6'd63) state_next = ST_LOAD;
      end
      ST_LOAD:  if (load_idx == 5'd16) state_next = ST_ROUND;
      ST_ROUND: if (round_counter == 7'd63) state_next = ST_FOLD;
      ST_FOLD: begin
        if (final_blk) state_next = ST_EMIT;
        else if (need_pad) state_next = ST_PAD;
        else state_next = ST_IDLE;
      end
      ST_EMIT:  if (out_ready && emit_idx == 3'd7) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      message_bit_count <= '0;
      round_counter <= '0;
      final_blk <= 1'b0;
      need_pad <= 1'b0;
      pad_pos <= '0;
      pad_mark_done <= 1'b0;
      emit_idx <= '0;
      load_idx <= '0;
      for (int i = 0; i < 8; i++) hash_words[i] <= INIT_HASH[i];
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (q_valid) begin
            if (q_req.has_byte) begin
              byte_position <= byte_position + 6'd1;
              message_bit_count <= message_bit_count + 64'd8;
            end
            // The mark follows the last byte; a full block wraps it to byte 0.
            pad_pos <= byte_position + 6'(q_req.has_byte);
            pad_mark_done <= 1'b0;
            final_blk <= 1'b0;
            need_pad <= q_req.last_byte;
            load_idx <= '0;
          end
        end
        ST_PAD: begin
          pad_pos <= pad_pos + 6'd1;
          if (!pad_mark_done) begin
            pad_mark_done <= 1'b1;
            // The length fits in this block only when the mark lands before it.
            final_blk <= (pad_pos < LEN_POS);
          end
          load_idx <= '0;
        end
        ST_LOAD: begin
          load_idx <= load_idx + 5'd1;
          if (load_idx != 5'd0) begin
            for (int i = 0; i < 15; i++) sched[i] <= sched[i + 1];
            sched[15] <= load_word;
          end
          for (int i = 0; i < 8; i++) wv[i] <= hash_words[i];
          round_counter <= '0;
        end
        ST_ROUND: begin
          round_counter <= round_counter + 7'd1;
          for (int i = 0; i < 15; i++) sched[i] <= sched[i + 1];
          sched[15] <= wt;
          wv[7] <= wv[6]; wv[6] <= wv[5]; wv[5] <= wv[4]; wv[4] <= wv[3] + t1;
          wv[3] <= wv[2]; wv[2] <= wv[1]; wv[1] <= wv[0]; wv[0] <= t1 + t2;
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) hash_words[i] <= hash_words[i] + wv[i];
          round_counter <= '0;
          byte_position <= '0;
          pad_pos <= '0;
          emit_idx <= '0;
          // With the mark already out, the next block is zeros and the length.
          if (!final_blk && need_pad) final_blk <= pad_mark_done;
        end
        ST_EMIT: begin
          if (out_ready) begin
            emit_idx <= emit_idx + 3'd1;
            if (emit_idx == 3'd7) begin
              for (int i = 0; i < 8; i++) hash_words[i] <= INIT_HASH[i];
              message_bit_count <= '0;
              byte_position <= '0;
              final_blk <= 1'b0;
              need_pad <= 1'b0;
              pad_mark_done <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = (state == ST_EMIT);
  assign out_word  = hash_words[emit_idx];
  assign out_index = emit_idx;
  assign out_last  = (emit_idx == 3'd7);

  `SHA_ASSERT_IMPL(a_round_range, clk, rst, (state == ST_ROUND) |-> !round_counter[6], "bad round")
  `SHA_ASSERT_IMPL(a_emit_hold, clk, rst, (out_valid && !out_ready) |=> out_valid, "word dropped")
  `SHA_ASSERT_NEVER(a_pop_busy, clk, rst, q_pop && state != ST_IDLE, "pop while busy")
endmodule

// File: hw/rtl/sha256_byte_stream_hasher.sv
// SHA-256 hasher: byte request stream in, eight digest words out per message.
// An accepted request is registered in the queue before the back end writes its byte; a
// full block then passes the load, round and fold states, while no request is popped. A
// last request adds padding from the mark position to the end of the block and those
// states per block (a second padded block when the mark lands at byte 56 or later), then
// eight digest words go out. rst is synchronous, active high, and restores the initial
// hash state; a four-entry queue lets the input flow while a block compresses.
module sha256_byte_stream_hasher
  import sha_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // has_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, zero fill
  output logic        m_tlast    // last_word
);
  req_t        in_req, q_req;
  logic        q_valid, q_pop;
  logic [31:0] word;
  logic [2:0]  idx;

  // Pack the incoming request for the front queue.
  assign in_req = '{data_byte: s_tdata, has_byte: s_tuser, last_byte: s_tlast};

  sha_front u_front (
    .clk, .rst,
    .in_valid(s_tvalid), .in_ready(s_tready), .in_req,
    .q_valid, .q_pop, .q_req
  );

  sha_back u_back (
    .clk, .rst,
    .q_valid, .q_pop, .q_req,
    .out_valid(m_tvalid), .out_ready(m_tready),
    .out_word(word), .out_index(idx), .out_last(m_tlast)
  );

  assign m_tdata = {5'd0, idx, word};
endmodule
